// File: rtl/tmuc_pkg.sv
`timescale 1ns / 1ps

package tmuc_pkg;

    localparam int NUM_TAGS = 11;
    localparam int FREE_TAG = 0;

    localparam int MODE_W  = 2;
    localparam int TAG_W   = 4;
    localparam int SIZE_W  = 31;
    localparam int BYTES_W = 64;
    localparam int EVT_W   = 32;

    localparam int ROW_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

    localparam logic [TAG_W:0]   NUM_TAGS_EXT = (TAG_W + 1)'(NUM_TAGS);
    localparam logic [TAG_W-1:0] RESERVED_TAG = TAG_W'(FREE_TAG);

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QTAG    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QTOTAL  = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } cmd_t;

    typedef struct packed {
        logic [BYTES_W-1:0] cur;
        logic [BYTES_W-1:0] peak;
        logic [BYTES_W-1:0] alc;
        logic [BYTES_W-1:0] frd;
        logic [EVT_W-1:0]   na;
        logic [EVT_W-1:0]   nf;
        logic [EVT_W-1:0]   nb;
    } row_t;

    typedef struct packed {
        logic status;
        row_t row;
    } result_t;

endpackage

// File: rtl/tmuc_front.sv
`timescale 1ns / 1ps

module tmuc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tmuc_pkg::MODE_W-1:0]   mode,
    input  logic [tmuc_pkg::TAG_W-1:0]    tag_index,
    input  logic [tmuc_pkg::SIZE_W-1:0]   byte_count,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output tmuc_pkg::cmd_t                cmd
);
    import tmuc_pkg::*;

    logic                  stats_enable_reg;
    cmd_t                  cmdq_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;
    logic                  in_xfer;
    logic                  is_event;
    logic                  tag_in_range;
    logic                  keep;
    logic                  enq;
    logic                  deq;

    // classify: drop events on the reserved tag, on tags out of range or while counting is off
    assign is_event     = (mode == MODE_ALLOC) || (mode == MODE_FREE);
    assign tag_in_range = {1'b0, tag_index} < NUM_TAGS_EXT;
    assign keep         = !is_event
                          || (stats_enable_reg && (tag_index != RESERVED_TAG) && tag_in_range);

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign in_xfer = push && !full;
    assign enq     = in_xfer && keep;

    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmdq_mem[rd_ptr_reg];
    assign deq       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_enable_reg <= 1'b1;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                stats_enable_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            cmdq_mem[wr_ptr_reg] <= '{op: mode, tag: tag_index, size: byte_count};
        end
    end

endmodule

// File: rtl/tmuc_back.sv
`timescale 1ns / 1ps

module tmuc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tmuc_pkg::cmd_t     cmd,
    output logic               empty,
    input  logic               pop,
    output tmuc_pkg::result_t  res
);
    import tmuc_pkg::*;

    localparam logic [ROW_W-1:0] WALK_FIRST = ROW_W'(FREE_TAG + 1);
    localparam logic [ROW_W-1:0] WALK_LAST  = ROW_W'(NUM_TAGS - 1);

    row_t                  rows_reg [NUM_TAGS];
    row_t                  rd_row;
    row_t                  new_row;
    row_t                  acc_reg;
    row_t                  acc_sum;
    logic                  walking_reg;
    logic [ROW_W-1:0]      walk_idx_reg;
    logic [ROW_W-1:0]      rd_idx;
    logic                  is_event_cmd;
    logic                  q_in_range;
    logic                  walk_last;
    logic                  res_space;
    logic                  cmd_xfer;
    logic                  upd_en;
    logic [BYTES_W-1:0]    size_ext;
    logic [BYTES_W-1:0]    cur_add;
    result_t               res_data;
    logic                  res_push;
    logic                  res_pop;
    result_t               resq_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] resq_wr_reg;
    logic [RESQ_PTR_W-1:0] resq_rd_reg;
    logic [RESQ_CNT_W-1:0] resq_count_reg;

    assign is_event_cmd = (cmd.op == MODE_ALLOC) || (cmd.op == MODE_FREE);
    assign q_in_range   = {1'b0, cmd.tag} < NUM_TAGS_EXT;
    assign walk_last    = (walk_idx_reg == WALK_LAST);
    assign res_space    = (resq_count_reg != RESQ_CNT_W'(RESQ_DEPTH));
    assign cmd_ready    = !walking_reg && (is_event_cmd || res_space);
    assign cmd_xfer     = cmd_valid && cmd_ready;
    assign upd_en       = cmd_xfer && is_event_cmd;

    assign rd_idx = walking_reg ? walk_idx_reg : cmd.tag[ROW_W-1:0];
    assign rd_row = rows_reg[rd_idx];

    // row update for one event
    assign size_ext = BYTES_W'(cmd.size);
    assign cur_add  = rd_row.cur + size_ext;

    always_comb
    begin
        new_row = rd_row;
        case (cmd.op)
            MODE_ALLOC:
            begin
                new_row.cur = cur_add;
                new_row.alc = rd_row.alc + size_ext;
                new_row.na  = rd_row.na + 1'b1;
                new_row.nb  = rd_row.nb + 1'b1;
                if ($signed(cur_add) > $signed(rd_row.peak))
                begin
                    new_row.peak = cur_add;
                end
            end
            MODE_FREE:
            begin
                new_row.cur = rd_row.cur - size_ext;
                new_row.frd = rd_row.frd + size_ext;
                new_row.nf  = rd_row.nf + 1'b1;
                if (rd_row.nb != '0)
                begin
                    new_row.nb = rd_row.nb - 1'b1;
                end
            end
            default:
            begin
                new_row = rd_row;
            end
        endcase
    end

    // total query accumulation, one row per cycle; the last row waits for result queue space
    always_comb
    begin
        acc_sum.cur  = acc_reg.cur  + rd_row.cur;
        acc_sum.peak = acc_reg.peak + rd_row.peak;
        acc_sum.alc  = acc_reg.alc  + rd_row.alc;
        acc_sum.frd  = acc_reg.frd  + rd_row.frd;
        acc_sum.na   = acc_reg.na   + rd_row.na;
        acc_sum.nf   = acc_reg.nf   + rd_row.nf;
        acc_sum.nb   = acc_reg.nb   + rd_row.nb;
    end

    always_comb
    begin
        res_push = 1'b0;
        res_data = '{status: STATUS_OK, row: acc_sum};
        if (walking_reg)
        begin
            res_push = walk_last && res_space;
        end
        else if (cmd_xfer && (cmd.op == MODE_QTAG))
        begin
            res_push = 1'b1;
            if (q_in_range)
            begin
                res_data = '{status: STATUS_OK, row: rd_row};
            end
            else
            begin
                res_data = '{status: STATUS_RANGE, row: '0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TAGS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            rows_reg[rd_idx] <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg  <= 1'b0;
            walk_idx_reg <= '0;
            acc_reg      <= '0;
        end
        else if (walking_reg)
        begin
            if (!walk_last)
            begin
                acc_reg      <= acc_sum;
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
            else if (res_space)
            begin
                walking_reg <= 1'b0;
            end
        end
        else if (cmd_xfer && (cmd.op == MODE_QTOTAL))
        begin
            walking_reg  <= 1'b1;
            walk_idx_reg <= WALK_FIRST;
            acc_reg      <= '0;
        end
    end

    // result queue
    assign empty   = (resq_count_reg == '0);
    assign res     = resq_mem[resq_rd_reg];
    assign res_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resq_wr_reg    <= '0;
            resq_rd_reg    <= '0;
            resq_count_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                resq_wr_reg <= (resq_wr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                               '0 : resq_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                resq_rd_reg <= (resq_rd_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                               '0 : resq_rd_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                resq_count_reg <= resq_count_reg + 1'b1;
            end
            else if (!res_push && res_pop)
            begin
                resq_count_reg <= resq_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            resq_mem[resq_wr_reg] <= res_data;
        end
    end

endmodule

// File: rtl/tagged_memory_usage_counters_core.sv
`timescale 1ns / 1ps

// Usage counters for up to NUM_TAGS memory tags (tag 0 is reserved and never counted).
// Allocation and free events update one row each and are taken one per cycle unless the
// command queue is full; they return nothing, and events on the reserved tag, on tags
// out of range or while stats_enable is low are accepted and dropped. A tag query
// writes its result into the result queue as the back end takes it. A total query
// walks rows 1 to NUM_TAGS-1 through the back end's single row read port, one row a
// cycle, and holds the back end until its result fits in the result queue; a
// four-entry command queue keeps the input open meanwhile. Results wait in a
// two-entry queue, the oldest shown while empty is low.
module tagged_memory_usage_counters_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [tmuc_pkg::MODE_W-1:0]          mode,
    input  logic [tmuc_pkg::TAG_W-1:0]           tag_index,
    input  logic [tmuc_pkg::SIZE_W-1:0]          byte_count,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 status,
    output logic signed [tmuc_pkg::BYTES_W-1:0]  current_bytes,
    output logic signed [tmuc_pkg::BYTES_W-1:0]  peak_bytes,
    output logic signed [tmuc_pkg::BYTES_W-1:0]  allocated_bytes,
    output logic signed [tmuc_pkg::BYTES_W-1:0]  freed_bytes,
    output logic [tmuc_pkg::EVT_W-1:0]           alloc_events,
    output logic [tmuc_pkg::EVT_W-1:0]           free_events,
    output logic [tmuc_pkg::EVT_W-1:0]           live_blocks
);
    import tmuc_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    result_t res;

    tmuc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .tag_index  (tag_index),
        .byte_count (byte_count),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    tmuc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign status          = res.status;
    assign current_bytes   = $signed(res.row.cur);
    assign peak_bytes      = $signed(res.row.peak);
    assign allocated_bytes = $signed(res.row.alc);
    assign freed_bytes     = $signed(res.row.frd);
    assign alloc_events    = res.row.na;
    assign free_events     = res.row.nf;
    assign live_blocks     = res.row.nb;

    // an event on the reserved tag never reaches the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cmd_valid && tag_index == RESERVED_TAG
         && (mode == MODE_ALLOC || mode == MODE_FREE)) |=> !cmd_valid)
        else $error("reserved-tag event entered the command queue");

    // a query always reaches the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cmd_valid && (mode == MODE_QTAG || mode == MODE_QTOTAL))
        |=> cmd_valid)
        else $error("query lost in the front end");

    // events are dropped once counting is switched off
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && !cfg_wdata) ##1
        (push && !full && !cmd_valid && (mode == MODE_ALLOC || mode == MODE_FREE))
        |=> !cmd_valid)
        else $error("event queued while counting disabled");

endmodule
